[rtl/fixed16_16_mul_div_unit_macros.svh]
// Assertion helpers for the fixed-point unit.
`ifndef FIXED16_16_MUL_DIV_UNIT_MACROS_SVH
`define FIXED16_16_MUL_DIV_UNIT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define FX_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define FX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/fxmd_pkg.sv]
`timescale 1ns / 1ps
package fxmd_pkg;
   localparam int unsigned DataWidth = 32;
   localparam int unsigned FracBits  = 16;
   localparam int unsigned DivSteps  = 4;  // quotient bits per stage
   localparam logic OP_MUL = 1'b0;
   localparam logic OP_DIV = 1'b1;
   localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] NEG_MAX = 32'h8000_0000;

   // Sideband carried down the operand and divider pipeline stages.
   typedef struct packed {
      logic op;
      logic neg;
      logic div_zero;
      logic a_neg;
   } ctl_type;

   function automatic logic [31:0] apply_sign(input logic neg, input logic [49:0] mag);
      logic [31:0] r;
      if (neg) begin
         if (mag >= 50'h0_8000_0000) r = NEG_MAX;
         else r = ~mag[31:0] + 32'd1;
      end else begin
         if (mag >= 50'h0_7FFF_FFFF) r = POS_MAX;
         else r = mag[31:0];
      end
      return r;
   endfunction
endpackage

[rtl/fxmd_div_stage.sv]
`timescale 1ns / 1ps
// One restoring-division stage: shifts in DivSteps dividend bits.
module fxmd_div_stage (
   input  logic [49:0] rem_in_val,
   input  logic [49:0] num_in_val,
   input  logic [33:0] den,
   output logic [49:0] rem_out_val,
   output logic [49:0] num_out_val
);
   always_comb begin
      logic [49:0] r;
      logic [49:0] n;
      r = rem_in_val;
      n = num_in_val;
      for (int i = 0; i < int'(fxmd_pkg::DivSteps); i++) begin
         r = {r[48:0], n[49]};
         n = {n[48:0], 1'b0};
         if (r >= {16'd0, den}) begin
            r = r - {16'd0, den};
            n[0] = 1'b1;
         end
      end
      rem_out_val = r;
      num_out_val = n;
   end
endmodule

[rtl/fixed16_16_mul_div_unit.sv]
`timescale 1ns / 1ps
// Signed 16.16 multiply / divide. req_tuser selects the operation (0 multiply,
// 1 divide); req_tdata carries operand_a in bits 31:0 and operand_b in 63:32.
// Multiply gives a*b/2^16, divide a*2^16/b, both rounded half away from zero
// and saturated; divide by zero saturates toward the sign of a. One beat is
// accepted every cycle while the skid is empty. Stages: one operand-magnitude
// stage, one numerator and product stage, a 13-stage divider (4 quotient bits
// per stage over a 50-bit scaled dividend), which the registered multiply path
// rides alongside, a sign and saturation stage, and the output register. While
// the output is blocked the pipeline keeps moving until the skid stage holds a
// beat, then freezes; ready comes straight from the skid flag.
module fixed16_16_mul_div_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [2*fxmd_pkg::DataWidth-1:0] req_tdata,  // operand_a, operand_b
   input  logic                             req_tuser,  // operation
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [fxmd_pkg::DataWidth-1:0]   rsp_tdata   // result
);
   localparam int unsigned NStg = 52 / fxmd_pkg::DivSteps; // 13 divider stages

   logic adv;
   logic [31:0] a_w, b_w;
   assign a_w = req_tdata[31:0];
   assign b_w = req_tdata[63:32];

   // stage 0: magnitudes and control
   logic v0_ff;
   fxmd_pkg::ctl_type c0_ff;
   logic [31:0] ma0_ff, mb0_ff;
   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (adv) v0_ff <= req_tvalid;
      if (adv) begin
         ma0_ff <= a_w[31] ? (~a_w + 32'd1) : a_w;
         mb0_ff <= b_w[31] ? (~b_w + 32'd1) : b_w;
         c0_ff.op <= req_tuser;
         c0_ff.a_neg <= a_w[31];
         c0_ff.div_zero <= (b_w == 32'd0);
         c0_ff.neg <= (a_w[31] ^ b_w[31]) && (a_w != 32'd0) && (b_w != 32'd0);
      end
   end

   // divider pipeline: numerator (ma<<17)+mb, divisor 2*mb. 52 shift steps
   // divide 4x the numerator. Product rides alongside for multiply.
   logic                 v_ff  [NStg+1];
   fxmd_pkg::ctl_type    c_ff  [NStg+1];
   logic [49:0]          r_ff  [NStg+1];
   logic [49:0]          n_ff  [NStg+1];
   logic [33:0]          d_ff  [NStg+1];
   logic [63:0]          p_ff  [NStg+1];
   logic [49:0]          r_in  [NStg];
   logic [49:0]          n_in  [NStg];

   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else if (adv) v_ff[0] <= v0_ff;
      if (adv) begin
         c_ff[0] <= c0_ff;
         p_ff[0] <= {32'd0, ma0_ff} * {32'd0, mb0_ff};
         r_ff[0] <= '0;
         n_ff[0] <= {1'b0, ma0_ff, 17'd0} + {18'd0, mb0_ff};
         d_ff[0] <= {1'b0, mb0_ff, 1'b0};
      end
   end

   for (genvar g = 0; g < NStg; g++) begin : g_div
      if (g < 13) begin : g_act
         fxmd_div_stage u_stage (
            .rem_in_val (r_ff[g]), .num_in_val (n_ff[g]), .den (d_ff[g]),
            .rem_out_val(r_in[g]), .num_out_val(n_in[g])
         );
      end
      always_ff @(posedge clock) begin
         if (reset) v_ff[g+1] <= 1'b0;
         else if (adv) v_ff[g+1] <= v_ff[g];
         if (adv) begin
            c_ff[g+1] <= c_ff[g];
            p_ff[g+1] <= p_ff[g];
            d_ff[g+1] <= d_ff[g];
            r_ff[g+1] <= r_in[g];
            n_ff[g+1] <= n_in[g];
         end
      end
   end

   // 13 stages x 4 bits = 52 shifts on a 50-bit numerator: the last two
   // steps shift in zeros, so n holds floor(4*num/den); drop two bits.
   logic [49:0] qmag_w, mmag_w, mag_w;
   logic [31:0] res_w;
   logic mneg_w;
   assign qmag_w = {2'b00, n_ff[NStg][49:2]};
   assign mmag_w = 50'((p_ff[NStg] + 64'd32768) >> fxmd_pkg::FracBits);
   assign mneg_w = c_ff[NStg].neg && (p_ff[NStg] != 64'd0);
   assign mag_w  = (c_ff[NStg].op == fxmd_pkg::OP_DIV) ? qmag_w : mmag_w;
   always_comb begin
      if (c_ff[NStg].op == fxmd_pkg::OP_DIV && c_ff[NStg].div_zero)
         res_w = c_ff[NStg].a_neg ? fxmd_pkg::NEG_MAX : fxmd_pkg::POS_MAX;
      else if (c_ff[NStg].op == fxmd_pkg::OP_DIV)
         res_w = fxmd_pkg::apply_sign(c_ff[NStg].neg, mag_w);
      else
         res_w = fxmd_pkg::apply_sign(mneg_w, mag_w);
   end

   // final stage then skid output
   logic vs_ff;
   logic [31:0] rs_ff;
   always_ff @(posedge clock) begin
      if (reset) vs_ff <= 1'b0;
      else if (adv) vs_ff <= v_ff[NStg];
      if (adv) rs_ff <= res_w;
   end

   logic ov_ff, sk_ff;
   logic [31:0] od_ff, sd_ff;
   logic [31:0] od_in;
   assign adv = !sk_ff;
   assign req_tready = adv;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign od_in = sk_ff ? sd_ff : rs_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
         sk_ff <= 1'b0;
      end else begin
         if (!ov_ff || rsp_tready) begin
            ov_ff <= sk_ff || vs_ff;
            sk_ff <= 1'b0;
         end else if (vs_ff && !sk_ff) begin
            sk_ff <= 1'b1;
         end
      end
      if (!ov_ff || rsp_tready) od_ff <= od_in;
      else if (vs_ff && !sk_ff) sd_ff <= rs_ff;
   end

`include "fixed16_16_mul_div_unit_macros.svh"
   `FX_ASSERT_IMPL(a_skid_needs_out, clock, reset, sk_ff, ov_ff, "skid full without output")
   `FX_ASSERT_NEXT(a_skid_drains, clock, reset, sk_ff && rsp_tready, !sk_ff, "skid not drained")
   `FX_ASSERT_IMPL(a_stall_holds, clock, reset, rsp_tvalid && !rsp_tready && !sk_ff && vs_ff, ##1 sk_ff, "beat lost on stall")
endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the 16.16 multiply / divide unit.

class fx_result_board;
   logic [31:0] pending[$];
   int          errors;

   function new();
      errors = 0;
   endfunction

   // magnitude of a 32-bit two's-complement value, -2^31 included
   static function logic [63:0] mag32(logic [31:0] v);
      return v[31] ? {32'd0, (~v + 32'd1)} : {32'd0, v};
   endfunction

   static function logic [31:0] signed_sat(logic neg, logic [63:0] mag);
      if (neg) return (mag >= 64'h8000_0000) ? fxmd_pkg::NEG_MAX : (~mag[31:0] + 32'd1);
      return (mag >= 64'h7FFF_FFFF) ? fxmd_pkg::POS_MAX : mag[31:0];
   endfunction

   static function logic [31:0] fx_answer(logic op, logic [31:0] a, logic [31:0] b);
      logic [63:0] ma, mb, prod, q;
      logic        neg;
      ma = mag32(a);
      mb = mag32(b);
      if (op == fxmd_pkg::OP_MUL) begin
         prod = ma * mb;
         neg  = (a[31] ^ b[31]) && (prod != 0);
         return signed_sat(neg, (prod + 64'd32768) >> 16);
      end
      if (b == 0) return a[31] ? fxmd_pkg::NEG_MAX : fxmd_pkg::POS_MAX;
      neg = (a[31] ^ b[31]) && (a != 0);
      // round half away: floor((2*ma*2^16 + mb) / (2*mb))
      q = ((ma << 17) + mb) / (mb << 1);
      return signed_sat(neg, q);
   endfunction

   function void note_operation(logic op, logic [31:0] a, logic [31:0] b);
      pending.push_back(fx_answer(op, a, b));
   endfunction

   function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (pending.size() == 0) begin
         $error("result with nothing pending: result=%h", got);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (got !== want) begin
         $error("result mismatch: expected %h actual %h", want, got);
         errors++;
      end
   endfunction
endclass

module tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;  // operand_a [31:0], operand_b [63:32]
   logic        req_tuser = 0;   // operation
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;       // result

   fx_result_board board = new();
   bit  sink_hold;        // long receiver hold-off, driven by the main test sequence
   bit  quiet;            // final stretch: no idling on either side
   int  cycles;
   localparam int CycleLimit = 400000;

   always #6 clock = ~clock;

   fixed16_16_mul_div_unit u_dut (.*);

   // Interesting operand values: extremes, zero, one, halves, rounding edges.
   logic [31:0] corner[$] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                              32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0000_7FFF,
                              32'h0002_0000, 32'h8000_0001, 32'h0000_0003};

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 5))
         0: return corner[$urandom_range(0, corner.size() - 1)];
         1: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000; // near zero
         2: return {{16{1'b0}}, 16'($urandom)} ^ {32{$urandom_range(0, 1) == 1}};
         default: return $urandom;
      endcase
   endfunction

   // One input beat; a random gap may follow unless in the quiet stretch.
   task automatic send_op(logic op, logic [31:0] a, logic [31:0] b);
      req_tvalid <= 1;
      req_tuser  <= op;
      req_tdata  <= {b, a};
      do @(posedge clock); while (!req_tready);
      board.note_operation(op, a, b);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   // Result side: accept and check; random stall bursts, plus the long hold.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
   end

   initial begin
      int burst;
      burst = 0;
      forever begin
         @(posedge clock);
         if (sink_hold) rsp_tready <= 0;
         else if (burst > 0 && !quiet) begin
            burst--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
            if (!quiet && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 11);
         end
      end
   end

   // Timeout watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("** fixed16_16_mul_div_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: corner pairs for both operations, divide by zero, zero dividend,
      // ties that round away from zero, both saturation directions.
      send_op(fxmd_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_op(fxmd_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
      send_op(fxmd_pkg::OP_MUL, 32'h8000_0000, 32'h7FFF_FFFF);
      send_op(fxmd_pkg::OP_MUL, 32'h0000_0001, 32'h0000_8000);  // tie, +
      send_op(fxmd_pkg::OP_MUL, 32'hFFFF_FFFF, 32'h0000_8000);  // tie, -
      send_op(fxmd_pkg::OP_MUL, 32'h0000_0001, 32'h0000_7FFF);
      send_op(fxmd_pkg::OP_MUL, 32'h0, 32'h8000_0000);
      send_op(fxmd_pkg::OP_MUL, 32'h8000_0000, 32'h0001_0000);
      send_op(fxmd_pkg::OP_MUL, 32'h8000_0000, 32'hFFFF_0000);  // +2^31 saturates
      send_op(fxmd_pkg::OP_DIV, 32'h0001_0000, 32'h0);
      send_op(fxmd_pkg::OP_DIV, 32'hFFFF_0000, 32'h0);
      send_op(fxmd_pkg::OP_DIV, 32'h0, 32'h0);
      send_op(fxmd_pkg::OP_DIV, 32'h0, 32'hFFFF_FFFF);
      send_op(fxmd_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_0000);
      send_op(fxmd_pkg::OP_DIV, 32'h8000_0000, 32'h0001_0000);
      send_op(fxmd_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h0000_0001);
      send_op(fxmd_pkg::OP_DIV, 32'h0000_0001, 32'h0002_0000);  // tie, +
      send_op(fxmd_pkg::OP_DIV, 32'hFFFF_FFFF, 32'h0002_0000);  // tie, -
      send_op(fxmd_pkg::OP_DIV, 32'h0000_0001, 32'h8000_0000);
      send_op(fxmd_pkg::OP_DIV, 32'h8000_0000, 32'h8000_0000);
      send_op(fxmd_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h8000_0001);

      // Sender pauses until everything is back.
      drain();

      // Receiver holds off while the sender keeps offering: pipeline fills.
      sink_hold = 1;
      fork
         repeat (60) send_op(1'($urandom), pick_operand(), pick_operand());
         begin
            repeat (80) @(posedge clock);
            sink_hold = 0;
         end
      join

      repeat (480) send_op(1'($urandom), pick_operand(), pick_operand());
      quiet = 1;
      repeat (90) send_op(1'($urandom), pick_operand(), pick_operand());

      drain();
      repeat (40) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("** fixed16_16_mul_div_unit: PASSED **");
      else
         $display("** fixed16_16_mul_div_unit: FAILED **");
      $finish;
   end
endmodule
